/* hdl/tta_pkg.sv */
// ----------------------------------------------------------------------------
// tta_pkg
// Shared constants and types of the thermistor temperature averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tta_pkg;

    localparam int WINDOW_LENGTH = 8;

    localparam int ADC_W  = 10;
    localparam int SER_W  = 20;
    localparam int COEF_W = 40;
    localparam int TEMP_W = 16;

    // restoring divider: 2^45 dividend, 64-bit divisor
    localparam int DIV_NW = 46;
    localparam int DIV_DW = 64;

    localparam logic [SER_W-1:0]         SERIES_RST = 20'd10000;
    localparam logic signed [COEF_W-1:0] COEF_A_RST = 40'sd1109681490;
    localparam logic signed [COEF_W-1:0] COEF_B_RST = 40'sd261508450;
    localparam logic signed [COEF_W-1:0] COEF_C_RST = 40'sd222014;

    localparam logic [63:0]       LN2_Q32    = 64'd2977044472;
    localparam logic [ADC_W-1:0]  ADC_MAX    = 10'd1023;
    localparam logic signed [47:0] KELVIN_C16 = 48'sd4368;

    typedef enum logic [1:0] {
        REG_SERIES = 2'd0,
        REG_COEF_A = 2'd1,
        REG_COEF_B = 2'd2,
        REG_COEF_C = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

/* hdl/thermistor_temperature_averager_top.sv */
// ----------------------------------------------------------------------------
// thermistor_temperature_averager_top
// Steinhart-Hart thermistor linearization with a moving-average window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: adc_sample [9:0]
//  m_*     | out | m_tvalid/m_tready | m_tdata: raw_celsius [15:0],
//          |     |                   |   filtered_celsius [31:16]; m_tuser: sample_invalid
//  apb     | in  | psel/penable      | series, coef_a, coef_b, coef_c at 8*i
//
// A valid sample goes through two normalize-and-32-squaring log2 runs and five 4-pass
// products on the shared multiplier, then the division (skipped when the denominator
// is zero), the window update and the mean product. A sample of 0 or 1023 goes
// straight to FIN with the last results. s_tready is high only while idle, and
// FIN holds while the previous word still waits in the output register.
// Reset clears the window valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermistor_temperature_averager_top #(
    parameter int WINDOW_LENGTH = tta_pkg::WINDOW_LENGTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // adc_sample [9:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // raw_celsius [15:0], filtered_celsius [31:16]
    output logic      [0:0]  m_tuser,   // sample_invalid
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    localparam int SUM_W  = tta_pkg::TEMP_W + $clog2(WINDOW_LENGTH);
    localparam int NW     = tta_pkg::DIV_NW;
    localparam int DW     = tta_pkg::DIV_DW;
    localparam int TW     = tta_pkg::TEMP_W;

    // mean by reciprocal multiplication, exact for every numerator below 2^SUM_W
    localparam int          MEAN_SH    = SUM_W + $clog2(WINDOW_LENGTH);
    localparam logic [31:0] MEAN_RECIP = 32'(((64'd1 << MEAN_SH) + 64'(WINDOW_LENGTH - 1))
                                             / 64'(WINDOW_LENGTH));

    typedef enum logic [3:0] {
        IDLE, NUM, LOAD_N, NORM, SQ_ISSUE, SQ_WAIT, PROD_ISSUE, PROD_WAIT,
        PROD_DONE, SUM, SDIV, DIV_WAIT, WIN_START, WIN_WAIT, MEAN_WAIT, FIN
    } state_t;

    typedef enum logic [2:0] {
        P_L, P_L2, P_L3, P_BL, P_CL3
    } prod_t;

    // ---------------- configuration ----------------
    logic [tta_pkg::SER_W-1:0]         series_reg;
    logic signed [tta_pkg::COEF_W-1:0] coef_a_reg;
    logic signed [tta_pkg::COEF_W-1:0] coef_b_reg;
    logic signed [tta_pkg::COEF_W-1:0] coef_c_reg;
    logic                              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg <= tta_pkg::SERIES_RST;
            coef_a_reg <= tta_pkg::COEF_A_RST;
            coef_b_reg <= tta_pkg::COEF_B_RST;
            coef_c_reg <= tta_pkg::COEF_C_RST;
        end
        else if (cfg_we)
        begin
            case (tta_pkg::reg_idx_t'(paddr[4:3]))
                tta_pkg::REG_SERIES: series_reg <= pwdata[tta_pkg::SER_W-1:0];
                tta_pkg::REG_COEF_A: coef_a_reg <= pwdata[tta_pkg::COEF_W-1:0];
                tta_pkg::REG_COEF_B: coef_b_reg <= pwdata[tta_pkg::COEF_W-1:0];
                tta_pkg::REG_COEF_C: coef_c_reg <= pwdata[tta_pkg::COEF_W-1:0];
                default:             series_reg <= series_reg;
            endcase
        end
    end

    always_comb
    begin
        case (tta_pkg::reg_idx_t'(paddr[4:3]))
            tta_pkg::REG_SERIES: prdata = 64'(series_reg);
            tta_pkg::REG_COEF_A: prdata = 64'($unsigned(coef_a_reg));
            tta_pkg::REG_COEF_B: prdata = 64'($unsigned(coef_b_reg));
            tta_pkg::REG_COEF_C: prdata = 64'($unsigned(coef_c_reg));
            default:             prdata = '0;
        endcase
    end

    // ---------------- datapath state ----------------
    state_t                state_reg;
    logic [9:0]            adc_reg;
    logic                  lg_sel_reg;
    logic [30:0]           m_reg;
    logic [4:0]            e_reg;
    logic [31:0]           frac_reg;
    logic [4:0]            cnt_reg;
    logic [36:0]           lnum_reg;
    prod_t                 pidx_reg;
    logic [1:0]            pp_reg;
    logic [127:0]          acc_reg;
    logic signed [63:0]    d_reg, l_reg, l2_reg, l3_reg, bl_reg, cl3_reg, s_reg;
    logic signed [TW-1:0]  raw_reg;
    logic                  mneg_reg;
    logic signed [TW-1:0]  last_raw_reg, last_filt_reg;
    logic signed [TW-1:0]  res_raw_reg, res_filt_reg;
    logic                  res_inv_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    // ---------------- shared multiplier ----------------
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic signed [63:0] op_a, op_b;
    logic [63:0]        ua, ub;
    logic [tta_pkg::SER_W-1:0] rs_eff;
    logic [31:0]        mean_num;

    tta_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    assign rs_eff = (series_reg == '0) ? tta_pkg::SER_W'(1) : series_reg;

    always_comb
    begin
        case (pidx_reg)
            P_L:     begin op_a = d_reg;  op_b = $signed(tta_pkg::LN2_Q32); end
            P_L2:    begin op_a = l_reg;  op_b = l_reg;  end
            P_L3:    begin op_a = l2_reg; op_b = l_reg;  end
            P_BL:    begin op_a = 64'(coef_b_reg); op_b = l_reg;  end
            P_CL3:   begin op_a = 64'(coef_c_reg); op_b = l3_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign ua = op_a[63] ? 64'(-op_a) : 64'(op_a);
    assign ub = op_b[63] ? 64'(-op_b) : 64'(op_b);

    always_comb
    begin
        case (state_reg)
            NUM:
            begin
                mul_a = 32'(rs_eff);
                mul_b = 32'(tta_pkg::ADC_MAX - adc_reg);
            end
            SQ_ISSUE:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            PROD_ISSUE:
            begin
                mul_a = pp_reg[0] ? ua[63:32] : ua[31:0];
                mul_b = pp_reg[1] ? ub[63:32] : ub[31:0];
            end
            WIN_WAIT:
            begin
                mul_a = mean_num;
                mul_b = MEAN_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // partial product placed by the sum of its half indexes
    logic [127:0] pp_shift;
    always_comb
    begin
        case (pp_reg)
            2'd0:    pp_shift = {64'b0, mul_p};
            2'd3:    pp_shift = {mul_p, 64'b0};
            default: pp_shift = {32'b0, mul_p, 32'b0};
        endcase
    end

    logic [127:0]       acc_rnd;
    logic [63:0]        prod_mag;
    logic signed [63:0] prod_res;
    assign acc_rnd  = acc_reg + 128'h8000_0000;
    assign prod_mag = {1'b0, acc_rnd[94:32]};
    assign prod_res = (op_a[63] ^ op_b[63]) ? $signed(64'(-prod_mag)) : $signed(prod_mag);

    // log2 squaring step
    logic [31:0] sq;
    logic [31:0] frac_next;
    logic [36:0] log_val;
    assign sq        = mul_p[61:30];
    assign frac_next = {frac_reg[30:0], sq[31]};
    assign log_val   = {e_reg, frac_next};

    // ---------------- divider ----------------
    logic          div_start, div_busy, div_done;
    logic [NW-1:0] div_num, div_q;
    logic [DW-1:0] div_den;
    logic [63:0]   s_mag;

    tta_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .busy(div_busy), .done(div_done), .quo(div_q)
    );

    // ---------------- window ----------------
    logic                    win_upd, win_done;
    logic signed [SUM_W-1:0] win_sum;
    logic [SUM_W-1:0]        sum_abs;

    tta_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_win (
        .clk(clk), .rst_n(rst_n), .upd(win_upd), .raw(raw_reg),
        .done(win_done), .sum(win_sum)
    );

    assign win_upd  = (state_reg == WIN_START);
    assign s_mag    = s_reg[63] ? 64'(-s_reg) : 64'(s_reg);
    assign sum_abs  = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
    assign mean_num = 32'(sum_abs) + 32'(WINDOW_LENGTH / 2);

    assign div_start = (state_reg == SDIV) && (s_reg != '0);
    assign div_num   = NW'(1) << (NW - 1);
    assign div_den   = s_mag;

    // round the quotient, give it the sign of S, go to Celsius, saturate
    logic [NW:0]          q_half;
    logic signed [47:0]   t_val;
    logic signed [TW-1:0] t_sat;
    always_comb
    begin
        q_half = ({1'b0, div_q} + (NW+1)'(1)) >> 1;
        t_val  = $signed(48'(q_half));
        if (s_reg[63])
            t_val = -t_val;
        t_val = t_val - tta_pkg::KELVIN_C16;
        if (t_val > 48'sd32767)
            t_sat = 16'sh7FFF;
        else if (t_val < -48'sd32768)
            t_sat = 16'sh8000;
        else
            t_sat = TW'(t_val);
    end

    logic [63:0]          mean_q;
    logic signed [TW-1:0] mean;
    assign mean_q = mul_p >> MEAN_SH;
    assign mean   = mneg_reg ? TW'(-mean_q[TW-1:0]) : mean_q[TW-1:0];

    logic out_load;
    assign out_load = (state_reg == FIN) && (!m_tvalid_reg || m_tready);

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            last_raw_reg  <= '0;
            last_filt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            lg_sel_reg    <= 1'b0;
            pidx_reg      <= P_L;
            pp_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        adc_reg <= s_tdata[9:0];
                        if (s_tdata[9:0] == '0 || s_tdata[9:0] == tta_pkg::ADC_MAX)
                        begin
                            res_raw_reg  <= last_raw_reg;
                            res_filt_reg <= last_filt_reg;
                            res_inv_reg  <= 1'b1;
                            state_reg    <= FIN;
                        end
                        else
                            state_reg <= NUM;
                    end
                end
                NUM:
                    state_reg <= LOAD_N;
                LOAD_N:
                begin
                    m_reg      <= mul_p[30:0];
                    e_reg      <= 5'd30;
                    lg_sel_reg <= 1'b0;
                    state_reg  <= NORM;
                end
                NORM:
                begin
                    if (m_reg[30])
                    begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= SQ_ISSUE;
                    end
                    else
                    begin
                        m_reg <= {m_reg[29:0], 1'b0};
                        e_reg <= e_reg - 5'd1;
                    end
                end
                SQ_ISSUE:
                    state_reg <= SQ_WAIT;
                SQ_WAIT:
                begin
                    frac_reg <= frac_next;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        if (!lg_sel_reg)
                        begin
                            lnum_reg   <= log_val;
                            m_reg      <= 31'(adc_reg);
                            e_reg      <= 5'd30;
                            lg_sel_reg <= 1'b1;
                            state_reg  <= NORM;
                        end
                        else
                        begin
                            d_reg     <= $signed(64'(lnum_reg) - 64'(log_val));
                            pidx_reg  <= P_L;
                            pp_reg    <= '0;
                            acc_reg   <= '0;
                            state_reg <= PROD_ISSUE;
                        end
                    end
                    else
                    begin
                        m_reg     <= sq[31] ? sq[31:1] : sq[30:0];
                        state_reg <= SQ_ISSUE;
                    end
                end
                PROD_ISSUE:
                    state_reg <= PROD_WAIT;
                PROD_WAIT:
                begin
                    acc_reg <= acc_reg + pp_shift;
                    pp_reg  <= pp_reg + 2'd1;
                    state_reg <= (pp_reg == 2'd3) ? PROD_DONE : PROD_ISSUE;
                end
                PROD_DONE:
                begin
                    acc_reg <= '0;
                    pp_reg  <= '0;
                    state_reg <= (pidx_reg == P_CL3) ? SUM : PROD_ISSUE;
                    case (pidx_reg)
                        P_L:     begin l_reg  <= prod_res; pidx_reg <= P_L2;  end
                        P_L2:    begin l2_reg <= prod_res; pidx_reg <= P_L3;  end
                        P_L3:    begin l3_reg <= prod_res; pidx_reg <= P_BL;  end
                        P_BL:    begin bl_reg <= prod_res; pidx_reg <= P_CL3; end
                        default:
                        begin
                            cl3_reg   <= prod_res;
                            pidx_reg  <= P_L;
                        end
                    endcase
                end
                SUM:
                begin
                    s_reg     <= 64'(coef_a_reg) + bl_reg + cl3_reg;
                    state_reg <= SDIV;
                end
                SDIV:
                begin
                    if (s_reg == '0)
                    begin
                        raw_reg   <= 16'sh7FFF;
                        state_reg <= WIN_START;
                    end
                    else
                        state_reg <= DIV_WAIT;
                end
                DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        raw_reg   <= t_sat;
                        state_reg <= WIN_START;
                    end
                end
                WIN_START:
                    state_reg <= WIN_WAIT;
                WIN_WAIT:
                begin
                    // the multiplier takes the rounded mean numerator this cycle
                    if (win_done)
                    begin
                        mneg_reg  <= win_sum[SUM_W-1];
                        state_reg <= MEAN_WAIT;
                    end
                end
                MEAN_WAIT:
                begin
                    res_raw_reg   <= raw_reg;
                    res_filt_reg  <= mean;
                    res_inv_reg   <= 1'b0;
                    last_raw_reg  <= raw_reg;
                    last_filt_reg <= mean;
                    state_reg     <= FIN;
                end
                FIN:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg <= {res_filt_reg, res_raw_reg};
                        m_tuser_reg <= res_inv_reg;
                        state_reg   <= IDLE;
                    end
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tdata[15:0] == last_raw_reg && m_tdata[31:16] == last_filt_reg)
        else $error("output word differs from remembered result");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

/* hdl/tta_mul.sv */
// ----------------------------------------------------------------------------
// tta_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tta_mul
(
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hdl/tta_div.sv */
// ----------------------------------------------------------------------------
// tta_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tta_div #(
    parameter int NW = tta_pkg::DIV_NW,
    parameter int DW = tta_pkg::DIV_DW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic               done,
    output logic      [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     num_reg;
    logic [NW-1:0]     quo_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;
    logic [DW:0]       trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
            num_reg <= {num_reg[NW-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* hdl/tta_window.sv */
// ----------------------------------------------------------------------------
// tta_window
// Ring window of recent temperatures with a running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tta_window #(
    parameter int WINDOW_LENGTH = tta_pkg::WINDOW_LENGTH,
    parameter int SUM_W         = tta_pkg::TEMP_W + $clog2(WINDOW_LENGTH)
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 upd,
    input  wire logic signed [tta_pkg::TEMP_W-1:0]    raw,
    output logic                                      done,
    output logic signed [SUM_W-1:0]                   sum
);

    localparam int PTR_W = $clog2(WINDOW_LENGTH);
    localparam int EXT_W = SUM_W - tta_pkg::TEMP_W;

    logic [tta_pkg::TEMP_W-1:0] mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0]   vld_reg;
    logic [tta_pkg::TEMP_W-1:0] rd_reg;
    logic                       rd_vld_reg;
    logic [PTR_W-1:0]           pos_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [tta_pkg::TEMP_W-1:0] old;

    // entries never written read as zero
    assign old = rd_vld_reg ? rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (upd)
            rd_reg <= mem[pos_reg];
        if (busy_reg)
            mem[pos_reg] <= raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            pos_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (upd)
            begin
                rd_vld_reg <= vld_reg[pos_reg];
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg         <= 1'b0;
                done_reg         <= 1'b1;
                vld_reg[pos_reg] <= 1'b1;
                sum_reg <= sum_reg + $signed({{EXT_W{raw[tta_pkg::TEMP_W-1]}}, raw})
                                   - $signed({{EXT_W{old[tta_pkg::TEMP_W-1]}}, old});
                if (pos_reg == PTR_W'(WINDOW_LENGTH - 1))
                    pos_reg <= '0;
                else
                    pos_reg <= pos_reg + PTR_W'(1);
            end
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire
